// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int CAP_W   = 11;
    localparam int TOTAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 3'd0,
        REQ_END   = 3'd1,
        REQ_ERROR = 3'd2,
        REQ_READ  = 3'd3,
        REQ_PEEK  = 3'd4,
        REQ_POP   = 3'd5
    } req_e;

    // result issued by the controller, data byte still in the store
    typedef struct packed {
        logic valid;
        logic byte_valid;
        logic last;
        logic write_accepted;
    } issue_t;

    typedef struct packed {
        logic               error_flag;
        logic               input_closed;
        logic               end_of_stream;
        logic [CAP_W-1:0]   fill_count;
        logic [CAP_W-1:0]   free_space;
        logic [TOTAL_W-1:0] bytes_written_total;
        logic [TOTAL_W-1:0] bytes_read_total;
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              byte_valid;
        logic              last;
        logic              write_accepted;
        status_t           status;
    } result_t;

endpackage

// ===== rtl/bsf_req_if.sv =====
interface bsf_req_if;
    logic                        valid;
    logic                        ready;
    logic [bsf_pkg::REQ_W-1:0]   req_type;
    logic [bsf_pkg::BYTE_W-1:0]  byte_in;
    logic [bsf_pkg::LEN_W-1:0]   length;

    modport source (output valid, output req_type, output byte_in, output length,
                    input ready);
    modport sink (input valid, input req_type, input byte_in, input length,
                  output ready);
endinterface

// ===== rtl/bsf_rsp_if.sv =====
interface bsf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bsf_pkg::BYTE_W-1:0]   byte_out;
    logic                         byte_valid;
    logic                         last;
    logic                         write_accepted;
    logic                         error_flag;
    logic                         input_closed;
    logic                         end_of_stream;
    logic [bsf_pkg::CAP_W-1:0]    fill_count;
    logic [bsf_pkg::CAP_W-1:0]    free_space;
    logic [bsf_pkg::TOTAL_W-1:0]  bytes_written_total;
    logic [bsf_pkg::TOTAL_W-1:0]  bytes_read_total;

    modport source (output valid, output byte_out, output byte_valid, output last,
                    output write_accepted, output error_flag, output input_closed,
                    output end_of_stream, output fill_count, output free_space,
                    output bytes_written_total, output bytes_read_total,
                    input ready);
    modport sink (input valid, input byte_out, input byte_valid, input last,
                  input write_accepted, input error_flag, input input_closed,
                  input end_of_stream, input fill_count, input free_space,
                  input bytes_written_total, input bytes_read_total,
                  output ready);
endinterface

// ===== rtl/bsf_ram.sv =====
module bsf_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bsf_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [bsf_pkg::BYTE_W-1:0] rdata
);

    logic [bsf_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bsf_ctrl.sv =====
module bsf_ctrl #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64,
    parameter int AW        = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bsf_pkg::CAP_W-1:0]  cfg_wr_data,
    bsf_req_if.sink                    req,
    input  logic                       can_issue,
    output bsf_pkg::issue_t            issue,
    output bsf_pkg::status_t           status,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [AW-1:0]              ram_raddr
);

    localparam int OW  = $clog2(DEPTH + 1);
    localparam int BW  = $clog2(MAX_BURST + 1);
    localparam int PW  = AW + 1;
    localparam int CW  = (OW > bsf_pkg::CAP_W) ? OW : bsf_pkg::CAP_W;
    localparam int LW  = (OW > BW) ? OW : BW;
    localparam int TW  = bsf_pkg::TOTAL_W;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [OW-1:0]             occ_reg, occ_next;
    logic [BW-1:0]             rem_reg, rem_next;
    logic                      ended_reg, ended_next;
    logic                      err_reg, err_next;
    logic [TW-1:0]             wcnt_reg, wcnt_next;
    logic [TW-1:0]             rcnt_reg, rcnt_next;
    logic [bsf_pkg::CAP_W-1:0] cap_reg;

    logic                      accept;
    logic [BW-1:0]             n_sat;
    logic                      n_big;
    logic [BW-1:0]             peek_n;
    logic [CW-1:0]             eff_cap;
    logic [CW-1:0]             free_cw;
    logic                      room;

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [PW-1:0] k);
        logic [PW-1:0] s;
        s = {1'b0, p} + k;
        if (s >= PW'(DEPTH))
        begin
            s = s - PW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [bsf_pkg::LEN_W-1:0] LEN_MAX();
        return bsf_pkg::LEN_W'(MAX_BURST);
    endfunction

    assign n_sat   = (req.length > LEN_MAX()) ? BW'(MAX_BURST) : BW'(req.length);
    assign n_big   = LW'(n_sat) > LW'(occ_reg);
    assign peek_n  = n_big ? BW'(occ_reg) : n_sat;
    assign eff_cap = (CW'(cap_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign room    = eff_cap > CW'(occ_reg);
    assign free_cw = room ? (eff_cap - CW'(occ_reg)) : '0;

    assign req.ready = (state_reg == ST_IDLE) && can_issue;
    assign accept    = req.valid && req.ready;
    assign ram_waddr = tail_reg;

    assign status.error_flag          = err_reg;
    assign status.input_closed        = ended_reg;
    assign status.end_of_stream       = ended_reg && (occ_reg == '0);
    assign status.fill_count          = bsf_pkg::CAP_W'(occ_reg);
    assign status.free_space          = bsf_pkg::CAP_W'(free_cw);
    assign status.bytes_written_total = wcnt_reg;
    assign status.bytes_read_total    = rcnt_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        occ_next   = occ_reg;
        rem_next   = rem_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        wcnt_next  = wcnt_reg;
        rcnt_next  = rcnt_reg;
        issue      = '0;
        ram_we     = 1'b0;
        ram_raddr  = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue.valid = 1'b1;
                    issue.last  = 1'b1;
                    unique case (bsf_pkg::req_e'(req.req_type))
                        bsf_pkg::REQ_WRITE:
                        begin
                            if (!ended_reg && !err_reg && room)
                            begin
                                ram_we               = 1'b1;
                                tail_next            = ptr_add(tail_reg, PW'(1));
                                occ_next             = occ_reg + OW'(1);
                                wcnt_next            = wcnt_reg + TW'(1);
                                issue.write_accepted = 1'b1;
                            end
                        end
                        bsf_pkg::REQ_END:
                        begin
                            ended_next = 1'b1;
                        end
                        bsf_pkg::REQ_ERROR:
                        begin
                            err_next = 1'b1;
                        end
                        bsf_pkg::REQ_READ, bsf_pkg::REQ_POP:
                        begin
                            if (n_big)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                head_next = ptr_add(head_reg, PW'(n_sat));
                                occ_next  = occ_reg - OW'(n_sat);
                                rcnt_next = rcnt_reg + TW'(n_sat);
                                if ((req.req_type == bsf_pkg::REQ_READ) && (n_sat != '0))
                                begin
                                    issue.byte_valid = 1'b1;
                                    issue.last       = (n_sat == BW'(1));
                                    ptr_next         = ptr_add(head_reg, PW'(1));
                                    rem_next         = n_sat - BW'(1);
                                    if (n_sat != BW'(1))
                                    begin
                                        state_next = ST_BURST;
                                    end
                                end
                            end
                        end
                        bsf_pkg::REQ_PEEK:
                        begin
                            if (peek_n != '0)
                            begin
                                issue.byte_valid = 1'b1;
                                issue.last       = (peek_n == BW'(1));
                                ptr_next         = ptr_add(head_reg, PW'(1));
                                rem_next         = peek_n - BW'(1);
                                if (peek_n != BW'(1))
                                begin
                                    state_next = ST_BURST;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                ram_raddr = ptr_reg;
                if (can_issue)
                begin
                    issue.valid      = 1'b1;
                    issue.byte_valid = 1'b1;
                    issue.last       = (rem_reg == BW'(1));
                    ptr_next         = ptr_add(ptr_reg, PW'(1));
                    rem_next         = rem_reg - BW'(1);
                    if (rem_reg == BW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            occ_reg   <= '0;
            rem_reg   <= '0;
            ended_reg <= 1'b0;
            err_reg   <= 1'b0;
            wcnt_reg  <= '0;
            rcnt_reg  <= '0;
            cap_reg   <= bsf_pkg::CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ptr_reg   <= ptr_next;
            occ_reg   <= occ_next;
            rem_reg   <= rem_next;
            ended_reg <= ended_next;
            err_reg   <= err_next;
            wcnt_reg  <= wcnt_next;
            rcnt_reg  <= rcnt_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(occ_reg) <= LW'(DEPTH))
        else $error("occupancy above store depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_add(head_reg, PW'(occ_reg)) == tail_reg)
        else $error("head, tail and occupancy disagree");

    a_burst_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> (rem_reg != '0) && !req.ready)
        else $error("burst state with nothing left to send");

endmodule

// ===== rtl/bsf_out.sv =====
module bsf_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsf_pkg::issue_t            issue,
    input  bsf_pkg::status_t           status,
    input  logic [bsf_pkg::BYTE_W-1:0] rdata,
    output logic                       can_issue,
    bsf_rsp_if.source                  rsp
);

    logic              s1_valid_reg;
    bsf_pkg::issue_t   s1_meta_reg;
    bsf_pkg::result_t  fifo_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;

    logic              push;
    logic              pop;
    bsf_pkg::result_t  push_item;
    bsf_pkg::result_t  head;

    // status is taken from the state registers in the cycle after issue,
    // when the whole request has already updated them
    assign push                     = s1_valid_reg;
    assign push_item.byte_out       = s1_meta_reg.byte_valid ? rdata : '0;
    assign push_item.byte_valid     = s1_meta_reg.byte_valid;
    assign push_item.last           = s1_meta_reg.last;
    assign push_item.write_accepted = s1_meta_reg.write_accepted;
    assign push_item.status         = status;

    assign head      = fifo_reg[rd_ptr_reg];
    assign rsp.valid = (cnt_reg != 2'd0);
    assign pop       = rsp.valid && rsp.ready;
    assign can_issue = (3'(cnt_reg) + 3'(s1_valid_reg) - 3'(pop)) < 3'd2;

    assign rsp.byte_out            = head.byte_out;
    assign rsp.byte_valid          = head.byte_valid;
    assign rsp.last                = head.last;
    assign rsp.write_accepted      = head.write_accepted;
    assign rsp.error_flag          = head.status.error_flag;
    assign rsp.input_closed        = head.status.input_closed;
    assign rsp.end_of_stream       = head.status.end_of_stream;
    assign rsp.fill_count          = head.status.fill_count;
    assign rsp.free_space          = head.status.free_space;
    assign rsp.bytes_written_total = head.status.bytes_written_total;
    assign rsp.bytes_read_total    = head.status.bytes_read_total;

    always_ff @(posedge clk)
    begin
        s1_meta_reg <= issue;
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) && s1_valid_reg |-> pop)
        else $error("result queue overflow");

    a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> can_issue)
        else $error("result issued without queue space");

endmodule

// ===== rtl/byte_stream_fifo_core.sv =====
// Channel  Dir  Fields
// req      in   req_type, byte_in, length
// rsp      out  byte_out, byte_valid, last, write_accepted, status, totals
// cfg      in   cfg_wr_en, cfg_wr_data (buffer capacity)
//
// Write, end, error, pop and status-only requests each give a single result.
// Read and peek of k bytes stream one byte per cycle from the store's read port while the result queue has room.
// A result passes through the issue register and then the result queue before it is valid on rsp.
// Reset clears pointers, flags and totals and sets capacity to 1024; store contents stay.
// Two-entry result queue: with rsp.ready low, requests and bursts pause once its entries are all filled or pending.
module byte_stream_fifo_core #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bsf_pkg::CAP_W-1:0] cfg_wr_data,
    bsf_req_if.sink                   req,
    bsf_rsp_if.source                 rsp
);

    localparam int AW = $clog2(DEPTH);

    bsf_pkg::issue_t            issue;
    bsf_pkg::status_t           status;
    logic                       can_issue;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [bsf_pkg::BYTE_W-1:0] ram_rdata;

    bsf_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .AW        (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .can_issue   (can_issue),
        .issue       (issue),
        .status      (status),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_raddr   (ram_raddr)
    );

    bsf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.byte_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .status    (status),
        .rdata     (ram_rdata),
        .can_issue (can_issue),
        .rsp       (rsp)
    );

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1024;
    localparam int BURST_MAX   = 64;
    localparam int DUE_SLOTS   = 4096;
    localparam int CHK_W       = bsf_pkg::TOTAL_W;
    localparam logic [bsf_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [bsf_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [bsf_pkg::CAP_W-1:0] cfg_wr_data;

    bsf_req_if req_ch ();
    bsf_rsp_if rsp_ch ();

    byte_stream_fifo_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // shadow copy of the fifo
    logic [bsf_pkg::BYTE_W-1:0]  shadow_store [0:STORE_DEPTH-1];
    logic [9:0]                  shadow_head;
    logic [9:0]                  shadow_tail;
    int                          shadow_fill;
    logic                        shadow_ended;
    logic                        shadow_error;
    logic [bsf_pkg::TOTAL_W-1:0] shadow_written;
    logic [bsf_pkg::TOTAL_W-1:0] shadow_read;
    logic [bsf_pkg::CAP_W-1:0]   shadow_capacity;

    // ring of expected results, written at request accept, read at response accept
    bsf_pkg::result_t due_list [DUE_SLOTS];
    int               due_wr;
    int               due_rd;

    int mismatches;
    int burst_left;
    bit steady_sender;
    int rsp_hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pending_results();
        return due_wr - due_rd;
    endfunction

    function automatic logic [bsf_pkg::BYTE_W-1:0] rand_byte();
        return bsf_pkg::BYTE_W'($urandom);
    endfunction

    function automatic logic [bsf_pkg::LEN_W-1:0] rand_len(input int hi);
        return bsf_pkg::LEN_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [bsf_pkg::REQ_W-1:0] rand_code();
        return bsf_pkg::REQ_W'($urandom_range(0, 7));
    endfunction

    function automatic int saturate_count(input logic [bsf_pkg::LEN_W-1:0] count);
        return (count > BURST_MAX) ? BURST_MAX : int'(count);
    endfunction

    function automatic void queue_result(input logic [bsf_pkg::BYTE_W-1:0] data,
                                         input logic bv, input logic lst, input logic acc);
        bsf_pkg::result_t r;
        int               cap_eff;
        cap_eff = (shadow_capacity > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_capacity);
        r.byte_out                   = data;
        r.byte_valid                 = bv;
        r.last                       = lst;
        r.write_accepted             = acc;
        r.status.error_flag          = shadow_error;
        r.status.input_closed        = shadow_ended;
        r.status.end_of_stream       = shadow_ended && (shadow_fill == 0);
        r.status.fill_count          = bsf_pkg::CAP_W'(shadow_fill);
        r.status.free_space          = (cap_eff > shadow_fill)
                                       ? bsf_pkg::CAP_W'(cap_eff - shadow_fill) : '0;
        r.status.bytes_written_total = shadow_written;
        r.status.bytes_read_total    = shadow_read;
        due_list[due_wr % DUE_SLOTS] = r;
        due_wr++;
    endfunction

    function automatic void step_shadow_fifo(input logic [bsf_pkg::REQ_W-1:0] code,
                                             input logic [bsf_pkg::BYTE_W-1:0] data,
                                             input logic [bsf_pkg::LEN_W-1:0] count);
        int         n;
        int         cap_eff;
        logic       acc;
        logic       streamed;
        logic [9:0] start;
        n        = saturate_count(count);
        acc      = 1'b0;
        streamed = 1'b0;
        cap_eff  = (shadow_capacity > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_capacity);
        case (code)
            bsf_pkg::REQ_WRITE:
            begin
                if (!shadow_ended && !shadow_error && cap_eff > shadow_fill)
                begin
                    shadow_store[shadow_tail] = data;
                    shadow_tail    = shadow_tail + 10'd1;
                    shadow_fill    = shadow_fill + 1;
                    shadow_written = shadow_written + 1;
                    acc = 1'b1;
                end
            end
            bsf_pkg::REQ_END:   shadow_ended = 1'b1;
            bsf_pkg::REQ_ERROR: shadow_error = 1'b1;
            bsf_pkg::REQ_READ, bsf_pkg::REQ_POP:
            begin
                if (n > shadow_fill)
                    shadow_error = 1'b1;
                else
                begin
                    start       = shadow_head;
                    shadow_head = shadow_head + 10'(n);
                    shadow_fill = shadow_fill - n;
                    shadow_read = shadow_read + bsf_pkg::TOTAL_W'(n);
                    if (code == bsf_pkg::REQ_READ && n > 0)
                    begin
                        for (int i = 0; i < n; i++)
                            queue_result(shadow_store[start + 10'(i)], 1'b1, i == n - 1, 1'b0);
                        streamed = 1'b1;
                    end
                end
            end
            bsf_pkg::REQ_PEEK:
            begin
                if (n > shadow_fill)
                    n = shadow_fill;
                for (int i = 0; i < n; i++)
                    queue_result(shadow_store[shadow_head + 10'(i)], 1'b1, i == n - 1, 1'b0);
                streamed = (n > 0);
            end
            default: ;
        endcase
        if (!streamed)
            queue_result('0, 1'b0, 1'b1, acc);
    endfunction

    task automatic send_request(input logic [bsf_pkg::REQ_W-1:0] code,
                                input logic [bsf_pkg::BYTE_W-1:0] data,
                                input logic [bsf_pkg::LEN_W-1:0] count);
        if (!steady_sender && burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.byte_in  <= data;
        req_ch.length   <= count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        step_shadow_fifo(code, data, count);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results() != 0);
    endtask

    task automatic set_capacity(input logic [bsf_pkg::CAP_W-1:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_capacity = value;
    endtask

    // count that a read or pop can satisfy
    function automatic logic [bsf_pkg::LEN_W-1:0] fitting_count();
        int room;
        int len;
        room = (shadow_fill < BURST_MAX) ? shadow_fill : BURST_MAX;
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(0, 127);
            if (saturate_count(bsf_pkg::LEN_W'(len)) > shadow_fill)
                len = $urandom_range(0, room);
        end
        else
            len = $urandom_range(0, (room < 8) ? room : 8);
        return bsf_pkg::LEN_W'(len);
    endfunction

    task automatic test_empty_requests();
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd0);
        send_request(bsf_pkg::REQ_PEEK, rand_byte(), 7'd5);
        send_request(bsf_pkg::REQ_POP, rand_byte(), 7'd0);
        send_request(REQ_SPARE6, rand_byte(), rand_len(127));
        send_request(REQ_SPARE7, rand_byte(), rand_len(127));
    endtask

    task automatic test_byte_extremes();
        send_request(bsf_pkg::REQ_WRITE, 8'h00, rand_len(127));
        send_request(bsf_pkg::REQ_WRITE, 8'hFF, rand_len(127));
        send_request(bsf_pkg::REQ_WRITE, 8'hA5, rand_len(127));
        send_request(bsf_pkg::REQ_WRITE, 8'h5A, rand_len(127));
        send_request(bsf_pkg::REQ_PEEK, rand_byte(), 7'd127);
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd2);
        send_request(bsf_pkg::REQ_POP, rand_byte(), 7'd1);
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd1);
    endtask

    task automatic test_capacity_limits();
        set_capacity(11'd0);
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        set_capacity(11'd3);
        repeat (4) send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        set_capacity(11'd2047);
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        // capacity dropped under the fill level
        set_capacity(11'd1);
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd4);
        set_capacity(bsf_pkg::CAP_RESET);
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        steady_sender = 1'b1;
        rsp_hold_off  = 250;
        repeat (40) send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd30);
        send_request(bsf_pkg::REQ_PEEK, rand_byte(), 7'd64);
        steady_sender = 1'b0;
        wait_results_drained();
        send_request(bsf_pkg::REQ_READ, rand_byte(), 7'd10);
    endtask

    task automatic test_random_traffic();
        logic [bsf_pkg::CAP_W-1:0] phase_cap [6];
        int                        sel;
        phase_cap[0] = 11'd1024;
        phase_cap[1] = 11'd5;
        phase_cap[2] = 11'($urandom_range(0, 2047));
        phase_cap[3] = 11'd2047;
        phase_cap[4] = 11'd64;
        phase_cap[5] = 11'($urandom_range(0, 2047));
        for (int p = 0; p < 6; p++)
        begin
            set_capacity(phase_cap[p]);
            repeat (60)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
                else if (sel < 60)
                    send_request(bsf_pkg::REQ_READ, rand_byte(), fitting_count());
                else if (sel < 72)
                    send_request(bsf_pkg::REQ_POP, rand_byte(), fitting_count());
                else if (sel < 90)
                    send_request(bsf_pkg::REQ_PEEK, rand_byte(), rand_len(127));
                else if (sel < 95)
                    send_request(bsf_pkg::REQ_PEEK, rand_byte(), rand_len(4));
                else
                    send_request(sel[0] ? REQ_SPARE6 : REQ_SPARE7, rand_byte(), rand_len(127));
            end
        end
        set_capacity(bsf_pkg::CAP_RESET);
    endtask

    task automatic test_end_and_error();
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_END, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_READ, rand_byte(),
                     bsf_pkg::LEN_W'((shadow_fill < BURST_MAX) ? shadow_fill : BURST_MAX));
        send_request(bsf_pkg::REQ_PEEK, rand_byte(), 7'd3);
        send_request(bsf_pkg::REQ_POP, rand_byte(), 7'd127);
        send_request(bsf_pkg::REQ_ERROR, rand_byte(), rand_len(127));
        send_request(bsf_pkg::REQ_WRITE, rand_byte(), rand_len(127));
        // anything goes once both flags are stuck
        repeat (30) send_request(rand_code(), rand_byte(), rand_len(127));
    endtask

    task automatic check_field(input string name, input logic [CHK_W-1:0] want,
                               input logic [CHK_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        bsf_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results() == 0)
                begin
                    $error("response with nothing outstanding: byte_out %0h",
                           rsp_ch.byte_out);
                    mismatches++;
                end
                else
                begin
                    want = due_list[due_rd % DUE_SLOTS];
                    due_rd++;
                    check_field("byte_out", CHK_W'(want.byte_out), CHK_W'(rsp_ch.byte_out));
                    check_field("byte_valid", CHK_W'(want.byte_valid),
                                CHK_W'(rsp_ch.byte_valid));
                    check_field("last", CHK_W'(want.last), CHK_W'(rsp_ch.last));
                    check_field("write_accepted", CHK_W'(want.write_accepted),
                                CHK_W'(rsp_ch.write_accepted));
                    check_field("error_flag", CHK_W'(want.status.error_flag),
                                CHK_W'(rsp_ch.error_flag));
                    check_field("input_closed", CHK_W'(want.status.input_closed),
                                CHK_W'(rsp_ch.input_closed));
                    check_field("end_of_stream", CHK_W'(want.status.end_of_stream),
                                CHK_W'(rsp_ch.end_of_stream));
                    check_field("fill_count", CHK_W'(want.status.fill_count),
                                CHK_W'(rsp_ch.fill_count));
                    check_field("free_space", CHK_W'(want.status.free_space),
                                CHK_W'(rsp_ch.free_space));
                    check_field("bytes_written_total", want.status.bytes_written_total,
                                rsp_ch.bytes_written_total);
                    check_field("bytes_read_total", want.status.bytes_read_total,
                                rsp_ch.bytes_read_total);
                end
            end
        end
    end

    initial
    begin
        int mode;
        int mode_left;
        mode_left = 0;
        mode      = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_off > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_off--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (mode_left % 5 != 0);
                endcase
            end
        end
    end

    initial
    begin
        int waited;
        mismatches      = 0;
        burst_left      = 0;
        steady_sender   = 1'b0;
        rsp_hold_off    = 0;
        due_wr          = 0;
        due_rd          = 0;
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_fill     = 0;
        shadow_ended    = 1'b0;
        shadow_error    = 1'b0;
        shadow_written  = '0;
        shadow_read     = '0;
        shadow_capacity = bsf_pkg::CAP_RESET;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= '0;
        req_ch.byte_in  <= '0;
        req_ch.length   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_requests();
        test_byte_extremes();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();
        test_end_and_error();

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results() != 0)
        begin
            $error("%0d responses never arrived", pending_results());
            mismatches++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
